// ----- rtl/fxo_pkg.sv -----
// Shared types and constants for the six-band FIR crossover.
// Field widths, request function codes, phase modes and the sequencer state type.
// No dependencies.
package fxo_pkg;

   // Fixed field widths of the sample and coefficient formats.
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 18;
   localparam int SET_BITS    = 3;
   localparam int INDEX_BITS  = 8;
   localparam int MODE_BITS   = 2;

   // Five lowpasses feed six output bands.
   localparam int NUM_LP    = 5;
   localparam int NUM_BANDS = NUM_LP + 1;

   // Request function codes.
   localparam logic FUNC_COEF   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Phase mode codes; any code other than linear runs the short filter.
   localparam logic [MODE_BITS-1:0] MODE_LINEAR  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MINIMUM = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LEGACY  = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/fir_six_band_crossover.sv -----
// Six-band FIR crossover: history and coefficient memories, tap sequencer, MAC lanes.
// Depends on fxo_pkg for field widths, function codes and the state type.
// A sample item steps run (taps issued), drain (MAC pipeline empties), then done
// (output register loaded once free). The MAC lanes step one tap per cycle over the
// single history read port; no new item is accepted until the last is back in idle.
// Reset clears the mode register, write pointers and fill counts; a history entry not
// yet written since reset reads as zero through the per-channel fill count.
module fir_six_band_crossover #(
   parameter int MAX_TAPS     = 256,
   parameter int SHORT_TAPS   = 128,
   parameter int LOWPASS_SETS = 5,
   parameter int CHANNELS     = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration port
   input  logic                                  csr_we,
   input  logic [fxo_pkg::MODE_BITS-1:0]         csr_wdata,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic                                  req_channel,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic [fxo_pkg::SET_BITS-1:0]          req_coef_set,
   input  logic [fxo_pkg::INDEX_BITS-1:0]        req_coef_index,
   input  logic signed [fxo_pkg::COEF_BITS-1:0]  req_coef_value,
   input  logic                                  req_block_end,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_out_channel,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_low,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_low_mid,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_mid,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_mid_high,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_high,
   output logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_top,
   output logic                                  rsp_out_block_end
);
   import fxo_pkg::*;

   // Derived sizes.
   localparam int LANES     = (LOWPASS_SETS < NUM_LP) ? LOWPASS_SETS : NUM_LP;
   localparam int SET_W     = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int TAP_W     = $clog2(MAX_TAPS);
   localparam int FILL_W    = $clog2(MAX_TAPS + 1);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HIST_DEPTH = CHANNELS * MAX_TAPS;
   localparam int HIST_AW   = $clog2(HIST_DEPTH);
   localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W     = PROD_W + TAP_W;
   localparam int DIFF_W    = ACC_W + 2;
   localparam int SHORT_EFF = (SHORT_TAPS > MAX_TAPS) ? MAX_TAPS : SHORT_TAPS;

   localparam logic [TAP_W-1:0] LAST_LONG    = TAP_W'(MAX_TAPS - 1);
   localparam logic [TAP_W-1:0] LAST_SHORT   = TAP_W'(SHORT_EFF - 1);
   localparam logic [TAP_W-1:0] CENTRE_LONG  = TAP_W'(MAX_TAPS / 2 - 1);
   localparam logic [TAP_W-1:0] CENTRE_SHORT = TAP_W'(SHORT_EFF / 2 - 1);
   localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(MAX_TAPS);

   localparam logic signed [DIFF_W-1:0] ROUND_HALF = DIFF_W'(2 ** (COEF_BITS - 2));
   localparam logic signed [DIFF_W-1:0] SAT_HI     = DIFF_W'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [DIFF_W-1:0] SAT_LO     = -SAT_HI - DIFF_W'(1);

   // Round-half-up result of a band sum, shifted to the sample format and saturated.
   function automatic logic signed [SAMPLE_BITS-1:0] sat_band(
      input logic signed [DIFF_W-1:0] d
   );
      logic signed [DIFF_W-1:0] q;
      q = d >>> (COEF_BITS - 1);
      if (q > SAT_HI) begin
         return SAMPLE_BITS'(SAT_HI);
      end else if (q < SAT_LO) begin
         return SAMPLE_BITS'(SAT_LO);
      end
      return SAMPLE_BITS'(q);
   endfunction

   // Control state.
   state_type                 state_ff, state_in;
   logic [MODE_BITS-1:0]      mode_ff, mode_in;
   logic [TAP_W-1:0]          ptr_ff  [CHANNELS];
   logic [FILL_W-1:0]         fill_ff [CHANNELS];
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   logic                      ch_ff;
   logic                      blk_ff;
   logic [HIST_AW-1:0]        base_ff;
   logic [TAP_W-1:0]          rd_off_ff;
   logic [TAP_W-1:0]          cnt_ff;
   logic [TAP_W-1:0]          last_ff;
   logic [TAP_W-1:0]          centre_ff;
   logic [FILL_W-1:0]         fill_cur_ff;

   // Memories and datapath.
   logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
   logic signed [COEF_BITS-1:0]   coef_mem [LANES][MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] hist_q_ff;
   logic signed [COEF_BITS-1:0]   coef_q_ff [LANES];
   logic                          s1_live_ff;
   logic                          s1_centre_ff;
   logic signed [PROD_W-1:0]      prod_ff [LANES];
   logic                          s2_live_ff;
   logic signed [SAMPLE_BITS-1:0] xc_ff;
   logic signed [ACC_W-1:0]       acc_ff  [NUM_LP];
   logic signed [DIFF_W-1:0]      diff_ff [NUM_BANDS];
   logic signed [DIFF_W-1:0]      diff_in [NUM_BANDS];
   logic signed [SAMPLE_BITS-1:0] band_ff [NUM_BANDS];
   logic                          rsp_ch_ff;
   logic                          rsp_blk_ff;

   // Decoded request.
   logic                  req_accept;
   logic [CH_W-1:0]       ch_idx;
   logic [SET_W-1:0]      set_idx;
   logic [TAP_W-1:0]      tap_idx;
   logic                  ch_ok;
   logic                  coef_we;
   logic                  smp_go;
   logic [FILL_W-1:0]     fill_inc;
   logic [TAP_W-1:0]      ptr_cur;
   logic [HIST_AW-1:0]    hist_wr_addr;
   logic [HIST_AW-1:0]    hist_rd_addr;
   logic                  issue;
   logic                  diff_ld;
   logic                  rsp_ld;
   logic                  out_free;

   assign req_accept = req_valid && !req_stall;
   assign ch_idx     = CH_W'(req_channel);
   assign set_idx    = SET_W'(req_coef_set);
   assign tap_idx    = TAP_W'(req_coef_index);
   assign ch_ok      = 32'(req_channel) < CHANNELS;
   assign coef_we    = req_accept && (req_func == FUNC_COEF)
                       && (32'(req_coef_set) < LANES) && (32'(req_coef_index) < MAX_TAPS);
   assign smp_go     = req_accept && (req_func == FUNC_SAMPLE) && ch_ok;
   assign ptr_cur    = ptr_ff[ch_idx];
   assign fill_inc   = (fill_ff[ch_idx] == FILL_FULL) ? FILL_FULL
                                                      : fill_ff[ch_idx] + FILL_W'(1);
   assign hist_wr_addr = HIST_AW'(32'(ch_idx) * MAX_TAPS) + HIST_AW'(ptr_cur);
   assign hist_rd_addr = base_ff + HIST_AW'(rd_off_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state and strobes.
   always_comb begin
      state_in = state_ff;
      issue    = 1'b0;
      diff_ld  = 1'b0;
      rsp_ld   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (smp_go) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (cnt_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               diff_ld  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_ld   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign mode_in      = csr_we ? csr_wdata : mode_ff;
   assign s1_valid_in  = issue;
   assign s2_valid_in  = s1_valid_ff;
   assign rsp_valid_in = rsp_ld || (rsp_valid_ff && rsp_stall);

   // Band differences with the rounding half folded in.
   always_comb begin
      diff_in[0] = DIFF_W'(acc_ff[0]) + ROUND_HALF;
      for (int k = 1; k < NUM_LP; k++) begin
         diff_in[k] = DIFF_W'(acc_ff[k]) - DIFF_W'(acc_ff[k-1]) + ROUND_HALF;
      end
      diff_in[NUM_LP] = (DIFF_W'(xc_ff) <<< (COEF_BITS - 1))
                        - DIFF_W'(acc_ff[NUM_LP-1]) + ROUND_HALF;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_LINEAR;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (smp_go) begin
            ptr_ff[ch_idx]  <= (ptr_cur == LAST_LONG) ? '0 : ptr_cur + TAP_W'(1);
            fill_ff[ch_idx] <= fill_inc;
         end
      end
   end

   // Per-item setup at acceptance and tap walk while running.
   always_ff @(posedge clock) begin
      if (smp_go) begin
         ch_ff       <= req_channel;
         blk_ff      <= req_block_end;
         base_ff     <= HIST_AW'(32'(ch_idx) * MAX_TAPS);
         rd_off_ff   <= ptr_cur;
         cnt_ff      <= '0;
         fill_cur_ff <= fill_inc;
         if (mode_ff == MODE_LINEAR) begin
            last_ff   <= LAST_LONG;
            centre_ff <= CENTRE_LONG;
         end else begin
            last_ff   <= LAST_SHORT;
            centre_ff <= CENTRE_SHORT;
         end
      end else if (issue) begin
         rd_off_ff <= (rd_off_ff == '0) ? LAST_LONG : rd_off_ff - TAP_W'(1);
         cnt_ff    <= cnt_ff + TAP_W'(1);
      end
   end

   // Sample history memory: written at acceptance, read once per tap.
   always_ff @(posedge clock) begin
      if (smp_go) begin
         hist_mem[hist_wr_addr] <= req_sample_value;
      end
      hist_q_ff <= hist_mem[hist_rd_addr];
   end

   // Coefficient banks, one per lowpass lane.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[set_idx][tap_idx] <= req_coef_value;
      end
      for (int k = 0; k < LANES; k++) begin
         coef_q_ff[k] <= coef_mem[k][cnt_ff];
      end
   end

   // Read stage flags: entry written since reset, and centre tap.
   always_ff @(posedge clock) begin
      s1_live_ff   <= FILL_W'(cnt_ff) < fill_cur_ff;
      s1_centre_ff <= (cnt_ff == centre_ff);
   end

   // Multiply stage and centre-tap capture.
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         prod_ff[k] <= hist_q_ff * coef_q_ff[k];
      end
      s2_live_ff <= s1_live_ff;
      if (smp_go) begin
         xc_ff <= '0;
      end else if (s1_valid_ff && s1_centre_ff && s1_live_ff) begin
         xc_ff <= hist_q_ff;
      end
   end

   // Accumulate stage; lanes beyond the loaded sets stay zero.
   always_ff @(posedge clock) begin
      if (smp_go) begin
         for (int k = 0; k < NUM_LP; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (s2_valid_ff && s2_live_ff) begin
         for (int k = 0; k < LANES; k++) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
         end
      end
   end

   // Band differences, then rounding and saturation into the output register.
   always_ff @(posedge clock) begin
      if (diff_ld) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            diff_ff[b] <= diff_in[b];
         end
      end
      if (rsp_ld) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            band_ff[b] <= sat_band(diff_ff[b]);
         end
         rsp_ch_ff  <= ch_ff;
         rsp_blk_ff <= blk_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_band_low      = band_ff[0];
   assign rsp_band_low_mid  = band_ff[1];
   assign rsp_band_mid      = band_ff[2];
   assign rsp_band_mid_high = band_ff[3];
   assign rsp_band_high     = band_ff[4];
   assign rsp_band_top      = band_ff[5];
   assign rsp_out_block_end = rsp_blk_ff;

   // A new result is only loaded from the final sequencer state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   // The MAC pipeline is empty whenever a new item may be accepted.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("MAC pipeline busy while idle");

   // The tap counter never runs past the selected filter length.
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= last_ff))
      else $error("tap counter past last tap");

   // Leaving the run state follows the issue of the last tap.
   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && (state_in == ST_DRAIN)) |=> s1_valid_ff)
      else $error("last tap not issued");

endmodule

// ----- test/fxo_band_checker.sv -----
// Checker for the six-band FIR crossover: watches the request, response and CSR ports,
// predicts the band outputs of every accepted sample item and compares them in order.
// Depends on fxo_pkg for field widths, function codes and phase mode codes.
module fxo_band_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fxo_pkg::MODE_BITS-1:0]          csr_wdata,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_func,
   input  logic                                   req_channel,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic [fxo_pkg::SET_BITS-1:0]           req_coef_set,
   input  logic [fxo_pkg::INDEX_BITS-1:0]         req_coef_index,
   input  logic signed [fxo_pkg::COEF_BITS-1:0]   req_coef_value,
   input  logic                                   req_block_end,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic                                   rsp_out_channel,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_low,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_low_mid,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_mid,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_mid_high,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_high,
   input  logic signed [fxo_pkg::SAMPLE_BITS-1:0] rsp_band_top,
   input  logic                                   rsp_out_block_end,
   input  logic                                   drain_done,
   output int                                     pending_bands,
   output int                                     fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fxo_pkg::*;

   localparam int CHANNEL_COUNT = 2;
   localparam int LONG_TAPS     = 256;
   localparam int SHORT_TAPS    = 128;
   localparam longint BAND_MAX  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint BAND_MIN  = -BAND_MAX - 1;

   // One expected response item.
   typedef struct packed {
      logic                   channel;
      logic [SAMPLE_BITS-1:0] low;
      logic [SAMPLE_BITS-1:0] low_mid;
      logic [SAMPLE_BITS-1:0] mid;
      logic [SAMPLE_BITS-1:0] mid_high;
      logic [SAMPLE_BITS-1:0] high;
      logic [SAMPLE_BITS-1:0] top;
      logic                   block_end;
   } band_set_type;

   // Shadow copy of the filter state.
   logic signed [SAMPLE_BITS-1:0] history [CHANNEL_COUNT][LONG_TAPS];
   logic signed [COEF_BITS-1:0]   lowpass [NUM_LP][LONG_TAPS];
   logic [INDEX_BITS-1:0]         write_ptr [CHANNEL_COUNT];
   logic [MODE_BITS-1:0]          tap_mode;
   band_set_type                  expected_bands [$];
   bit                            leftover_checked;

   // Round half up from the product format to Q1.23 and saturate.
   function automatic logic [SAMPLE_BITS-1:0] round_saturate(input longint acc);
      longint v;
      v = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
      if (v > BAND_MAX) v = BAND_MAX;
      else if (v < BAND_MIN) v = BAND_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // Push one sample into its delay line and compute all six bands.
   function automatic band_set_type filter_sample(input logic ch,
                                                  input logic signed [SAMPLE_BITS-1:0] value,
                                                  input logic blk);
      longint                acc [NUM_LP];
      longint                centre_term;
      logic [INDEX_BITS-1:0] ptr;
      logic [INDEX_BITS-1:0] pos;
      int                    taps;
      band_set_type          r;
      ptr = write_ptr[ch];
      history[ch][ptr] = value;
      // Every code other than linear runs the short filter.
      taps = (tap_mode == MODE_LINEAR) ? LONG_TAPS : SHORT_TAPS;
      for (int k = 0; k < NUM_LP; k++) begin
         acc[k] = 0;
         for (int i = 0; i < taps; i++) begin
            pos = ptr - INDEX_BITS'(i);
            acc[k] += longint'(history[ch][pos]) * longint'(lowpass[k][i]);
         end
      end
      pos = ptr - INDEX_BITS'(taps / 2 - 1);
      centre_term = longint'(history[ch][pos]) * (longint'(1) <<< (COEF_BITS - 1));
      r.channel   = ch;
      r.low       = round_saturate(acc[0]);
      r.low_mid   = round_saturate(acc[1] - acc[0]);
      r.mid       = round_saturate(acc[2] - acc[1]);
      r.mid_high  = round_saturate(acc[3] - acc[2]);
      r.high      = round_saturate(acc[4] - acc[3]);
      r.top       = round_saturate(centre_term - acc[4]);
      r.block_end = blk;
      write_ptr[ch] = ptr + 1'b1;
      return r;
   endfunction

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("band check: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] got,
                              input logic [SAMPLE_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got), $signed(want)));
   endtask

   // Compare responses first, then predict the request accepted at the same edge.
   always @(posedge clock) begin
      band_set_type want;
      if (reset) begin
         tap_mode = MODE_LINEAR;
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            write_ptr[c] = '0;
            for (int t = 0; t < LONG_TAPS; t++) history[c][t] = '0;
         end
         expected_bands.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bands.size() == 0) begin
               report_mismatch("response item with no sample waiting");
            end else begin
               want = expected_bands.pop_front();
               check_field("out_channel", SAMPLE_BITS'(rsp_out_channel),
                           SAMPLE_BITS'(want.channel));
               check_field("band_low", rsp_band_low, want.low);
               check_field("band_low_mid", rsp_band_low_mid, want.low_mid);
               check_field("band_mid", rsp_band_mid, want.mid);
               check_field("band_mid_high", rsp_band_mid_high, want.mid_high);
               check_field("band_high", rsp_band_high, want.high);
               check_field("band_top", rsp_band_top, want.top);
               check_field("out_block_end", SAMPLE_BITS'(rsp_out_block_end),
                           SAMPLE_BITS'(want.block_end));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_COEF) begin
               // Loads to a set beyond the last lowpass are dropped.
               if (req_coef_set < NUM_LP) lowpass[req_coef_set][req_coef_index] = req_coef_value;
            end else begin
               expected_bands.push_back(filter_sample(req_channel, req_sample_value,
                                                      req_block_end));
            end
         end
         if (csr_we) tap_mode = csr_wdata;
         if (drain_done && !leftover_checked) begin
            if (expected_bands.size() != 0)
               report_mismatch($sformatf("%0d expected items never arrived",
                                         expected_bands.size()));
            leftover_checked = 1'b1;
         end
      end
      pending_bands <= expected_bands.size();
   end

endmodule

// ----- test/fir_six_band_crossover_test.sv -----
// Top of the crossover testbench: clock, reset, stimulus, stall control and verdict.
// Depends on fxo_pkg, the fir_six_band_crossover block and the fxo_band_checker module.
module fir_six_band_crossover_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fxo_pkg::*;

   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 156;
   localparam int FILL_TAPS      = 256;
   localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = 18'sh1FFFF;
   localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = 18'sh20000;

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          csr_we            = 1'b0;
   logic [MODE_BITS-1:0]          csr_wdata         = MODE_LINEAR;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic                          req_func          = FUNC_COEF;
   logic                          req_channel       = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_sample_value  = '0;
   logic [SET_BITS-1:0]           req_coef_set      = '0;
   logic [INDEX_BITS-1:0]         req_coef_index    = '0;
   logic signed [COEF_BITS-1:0]   req_coef_value    = '0;
   logic                          req_block_end     = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic                          rsp_out_channel;
   logic signed [SAMPLE_BITS-1:0] rsp_band_low;
   logic signed [SAMPLE_BITS-1:0] rsp_band_low_mid;
   logic signed [SAMPLE_BITS-1:0] rsp_band_mid;
   logic signed [SAMPLE_BITS-1:0] rsp_band_mid_high;
   logic signed [SAMPLE_BITS-1:0] rsp_band_high;
   logic signed [SAMPLE_BITS-1:0] rsp_band_top;
   logic                          rsp_out_block_end;
   logic                          drain_done        = 1'b0;
   int                            pending_bands;
   int                            fail_count;

   // Idle and stall rates of the current phase, in percent.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_request  = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   fir_six_band_crossover dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_channel       (req_channel),
      .req_sample_value  (req_sample_value),
      .req_coef_set      (req_coef_set),
      .req_coef_index    (req_coef_index),
      .req_coef_value    (req_coef_value),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_band_low      (rsp_band_low),
      .rsp_band_low_mid  (rsp_band_low_mid),
      .rsp_band_mid      (rsp_band_mid),
      .rsp_band_mid_high (rsp_band_mid_high),
      .rsp_band_high     (rsp_band_high),
      .rsp_band_top      (rsp_band_top),
      .rsp_out_block_end (rsp_out_block_end)
   );

   fxo_band_checker band_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_channel       (req_channel),
      .req_sample_value  (req_sample_value),
      .req_coef_set      (req_coef_set),
      .req_coef_index    (req_coef_index),
      .req_coef_value    (req_coef_value),
      .req_block_end     (req_block_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_band_low      (rsp_band_low),
      .rsp_band_low_mid  (rsp_band_low_mid),
      .rsp_band_mid      (rsp_band_mid),
      .rsp_band_mid_high (rsp_band_mid_high),
      .rsp_band_high     (rsp_band_high),
      .rsp_band_top      (rsp_band_top),
      .rsp_out_block_end (rsp_out_block_end),
      .drain_done        (drain_done),
      .pending_bands     (pending_bands),
      .fail_count        (fail_count)
   );

   // Mostly moderate samples so that bands stay in range, with extremes and full-scale noise.
   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      int v;
      case ($urandom_range(9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3, 4: return SAMPLE_BITS'($urandom);
         default: begin
            v = int'($urandom_range(131071)) - 65536;
            return SAMPLE_BITS'(v);
         end
      endcase
   endfunction

   // Mostly small taps; a few extremes and full-range values drive saturation.
   function automatic logic signed [COEF_BITS-1:0] rand_coef();
      int v;
      case ($urandom_range(63))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2, 3: return COEF_BITS'($urandom);
         default: begin
            v = int'($urandom_range(4095)) - 2048;
            return COEF_BITS'(v);
         end
      endcase
   endfunction

   // Offer one item after a random gap and hold it until it is accepted.
   task automatic drive_item(input logic func, input logic ch,
                             input logic signed [SAMPLE_BITS-1:0] sample,
                             input logic [SET_BITS-1:0] set, input logic [INDEX_BITS-1:0] idx,
                             input logic signed [COEF_BITS-1:0] coef, input logic blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_channel      <= ch;
      req_sample_value <= sample;
      req_coef_set     <= set;
      req_coef_index   <= idx;
      req_coef_value   <= coef;
      req_block_end    <= blk;
      do @(posedge clock); while (req_stall);
   endtask

   // Fields that an item does not use still carry random bits.
   task automatic send_coef(input logic [SET_BITS-1:0] set, input logic [INDEX_BITS-1:0] idx,
                            input logic signed [COEF_BITS-1:0] coef);
      drive_item(FUNC_COEF, 1'($urandom), SAMPLE_BITS'($urandom), set, idx, coef,
                 1'($urandom));
   endtask

   task automatic send_sample(input logic ch, input logic signed [SAMPLE_BITS-1:0] sample,
                              input logic blk);
      drive_item(FUNC_SAMPLE, ch, sample, SET_BITS'($urandom), INDEX_BITS'($urandom),
                 COEF_BITS'($urandom), blk);
   endtask

   // Stop offering, wait for every expected item, then let the block settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_bands != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_BITS-1:0] mode);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Watchdog: end the run once nothing has been accepted for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("fir_six_band_crossover regression: fail");
      $finish;
   end

   initial begin : stimulus
      int r;
      logic [MODE_BITS-1:0] mode;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(MODE_LINEAR);

      // Fill every tap of every lowpass before the first sample reads them.
      for (int s = 0; s < NUM_LP; s++) begin
         for (int t = 0; t < FILL_TAPS; t++) send_coef(SET_BITS'(s), INDEX_BITS'(t), rand_coef());
      end

      // Directed items: sets past the last lowpass, extreme taps and extreme samples.
      send_coef(3'd5, 8'd0, COEF_MAX);
      send_coef(3'd6, 8'd128, COEF_MIN);
      send_coef(3'd7, 8'd255, COEF_MAX);
      send_coef(3'd0, 8'd0, COEF_MAX);
      send_coef(3'd4, 8'd255, COEF_MIN);
      send_coef(3'd2, 8'd127, COEF_MAX);
      send_sample(1'b0, SAMPLE_MAX, 1'b1);
      send_sample(1'b1, SAMPLE_MIN, 1'b0);
      send_sample(1'b0, SAMPLE_MIN, 1'b0);
      send_sample(1'b1, SAMPLE_MAX, 1'b1);
      send_sample(1'b0, '0, 1'b0);
      send_sample(1'b1, -24'sd1, 1'b0);
      send_sample(1'b0, 24'sd1, 1'b1);
      send_sample(1'b0, SAMPLE_MAX, 1'b0);
      send_sample(1'b0, SAMPLE_MAX, 1'b0);
      send_coef(3'd0, 8'd0, COEF_MIN);
      send_sample(1'b1, SAMPLE_MIN, 1'b1);
      send_sample(1'b0, SAMPLE_MIN, 1'b0);

      // Random phases, each with its own phase mode and idle profile.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_for_drain();
         case (p % 4)
            0: mode = MODE_LINEAR;
            1: mode = MODE_MINIMUM;
            2: mode = MODE_LEGACY;
            default: mode = MODE_SPARE;
         endcase
         if (p == 5) mode = MODE_LINEAR;
         write_mode(mode);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once, hold the receiver off so the block backs up into its input.
            if (p == 4 && n == 10) hold_request = 1'b1;
            r = $urandom_range(99);
            if (r < 55) send_sample(1'($urandom), rand_sample(), 1'($urandom));
            else if (r < 92) send_coef(SET_BITS'($urandom_range(NUM_LP - 1)),
                                       INDEX_BITS'($urandom), rand_coef());
            else send_coef(SET_BITS'($urandom_range(7, NUM_LP)), INDEX_BITS'($urandom),
                           COEF_BITS'($urandom));
         end
      end

      wait_for_drain();
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) $display("fir_six_band_crossover regression: pass");
      else $display("fir_six_band_crossover regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/fxo_pkg.sv
rtl/fir_six_band_crossover.sv
test/fxo_band_checker.sv
test/fir_six_band_crossover_test.sv
